// ===== rtl/core/keyboard_scancode_to_ascii_assert.svh =====
// Assertion macros shared by the keyboard scan code decoder RTL.
// Included by files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef KEYBOARD_SCANCODE_TO_ASCII_ASSERT_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define KSA_ASSERT_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("kbd assertion failed");

// Next-cycle implication, disabled during reset.
`define KSA_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("kbd assertion failed");

`else

`define KSA_ASSERT_IMPLIES(name, pre, post)
`define KSA_ASSERT_NEXT(name, pre, post)

`endif

`endif

// ===== rtl/core/kbd_pkg.sv =====
// Package for the keyboard scan code decoder: key codes, types and the key ROMs.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kbd_pkg;

  localparam int unsigned KeyCount = 96;
  localparam int unsigned KeyW     = $clog2(KeyCount);

  typedef logic [KeyW-1:0] key_t;

  localparam logic [7:0] PrefixExt = 8'hE0;
  localparam key_t       KeyLast   = 7'h5F;
  localparam key_t       KCaps     = 7'h3A;
  localparam key_t       KNum      = 7'h45;
  localparam key_t       KScroll   = 7'h46;
  localparam key_t       KLshift   = 7'h2A;
  localparam key_t       KRshift   = 7'h36;
  localparam key_t       KSlash    = 7'h35;

  // Lock and modifier view of the state, as seen by the decoder.
  typedef struct packed {
    logic ext_pending;
    logic caps;
    logic num;
    logic scroll;
    logic lshift;
    logic rshift;
  } kbd_status_t;

  // State update for one processed byte.
  typedef struct packed {
    logic commit;     // byte consumed: extended flag takes ext_d
    logic ext_d;
    logic kd_we;      // write one key_down bit
    key_t kd_key;
    logic kd_col;
    logic kd_set;
    logic tog_caps;
    logic tog_num;
    logic tog_scroll;
  } kbd_update_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       leds_changed;
    logic [2:0] led_bits;
  } kbd_result_t;

  function automatic logic [6:0] rom_plain(input key_t key);
    logic [6:0] c;
    case (key)
      7'h01: c = 7'h1B; 7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33;
      7'h05: c = 7'h34; 7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37;
      7'h09: c = 7'h38; 7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
      7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
      7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
      7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A; 7'h1E: c = 7'h61; 7'h1F: c = 7'h73;
      7'h20: c = 7'h64; 7'h21: c = 7'h66; 7'h22: c = 7'h67; 7'h23: c = 7'h68;
      7'h24: c = 7'h6A; 7'h25: c = 7'h6B; 7'h26: c = 7'h6C; 7'h27: c = 7'h3B;
      7'h28: c = 7'h27; 7'h29: c = 7'h60; 7'h2B: c = 7'h5C; 7'h2C: c = 7'h7A;
      7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
      7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
      7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31; 7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30;
      7'h53: c = 7'h2E;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] rom_shift(input key_t key);
    logic [6:0] c;
    case (key)
      7'h01: c = 7'h1B; 7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23;
      7'h05: c = 7'h24; 7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26;
      7'h09: c = 7'h2A; 7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F;
      7'h0D: c = 7'h2B; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
      7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
      7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
      7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D;
      7'h1C: c = 7'h0A; 7'h1E: c = 7'h41; 7'h1F: c = 7'h53;
      7'h20: c = 7'h44; 7'h21: c = 7'h46; 7'h22: c = 7'h47; 7'h23: c = 7'h48;
      7'h24: c = 7'h4A; 7'h25: c = 7'h4B; 7'h26: c = 7'h4C; 7'h27: c = 7'h3A;
      7'h28: c = 7'h22; 7'h29: c = 7'h7E; 7'h2B: c = 7'h7C; 7'h2C: c = 7'h5A;
      7'h2D: c = 7'h58; 7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
      7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h3C;
      7'h34: c = 7'h3E; 7'h35: c = 7'h3F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h4A: c = 7'h2D; 7'h4E: c = 7'h2B; 7'h53: c = 7'h7F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/kbd_state.sv =====
// Decoder state: down bits of the plain shift keys, lock bits and the extended prefix flag.
// Depends on kbd_pkg.
`timescale 1ns / 1ps

module kbd_state
  import kbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kbd_update_t upd_i,
  output kbd_status_t status_o
);

  // Only the plain column of the two shift keys is ever looked at, so the rest of
  // the per-key down table has no effect on any result and is not stored.
  logic       lshift_q, rshift_q;
  logic       ext_q, caps_q, num_q, scroll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lshift_q <= 1'b0;
      rshift_q <= 1'b0;
    end else if (upd_i.kd_we && !upd_i.kd_col) begin
      if (upd_i.kd_key == KLshift) begin
        lshift_q <= upd_i.kd_set;
      end
      if (upd_i.kd_key == KRshift) begin
        rshift_q <= upd_i.kd_set;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q    <= 1'b0;
      caps_q   <= 1'b0;
      num_q    <= 1'b0;
      scroll_q <= 1'b0;
    end else if (upd_i.commit) begin
      ext_q    <= upd_i.ext_d;
      caps_q   <= caps_q ^ upd_i.tog_caps;
      num_q    <= num_q ^ upd_i.tog_num;
      scroll_q <= scroll_q ^ upd_i.tog_scroll;
    end
  end

  // only the plain column of the two shift keys counts as shift
  assign status_o = '{
    ext_pending: ext_q,
    caps:        caps_q,
    num:         num_q,
    scroll:      scroll_q,
    lshift:      lshift_q,
    rshift:      rshift_q
  };

endmodule

// ===== rtl/core/kbd_decode.sv =====
// Single-pass decode of one scan byte: state update and result item.
// Depends on kbd_pkg (key codes, ROM functions, structs).
`timescale 1ns / 1ps

module kbd_decode
  import kbd_pkg::*;
(
  input  logic        valid_i,
  input  logic [7:0]  scan_byte_i,
  input  kbd_status_t status_i,
  output kbd_update_t upd_o,
  output logic        emit_o,
  output kbd_result_t result_o
);

  logic       is_prefix, brk, key_ok, col, make, led, letter, shift;
  logic       tog_caps, tog_num, tog_scroll, caps_n, num_n, scroll_n;
  logic       lshift_n, rshift_n;
  key_t       key;
  logic [6:0] ch_plain, ch_shift, ch;

  always_comb begin
    is_prefix = (scan_byte_i == PrefixExt);
    key       = scan_byte_i[6:0];
    brk       = scan_byte_i[7];
    col       = status_i.ext_pending;
    key_ok    = !is_prefix && (key <= KeyLast);
    make      = key_ok && !brk;

    tog_num    = make && (key == KNum);
    tog_caps   = make && (key == KCaps);
    tog_scroll = make && (key == KScroll);
    led        = tog_num || tog_caps || tog_scroll;

    caps_n   = status_i.caps ^ tog_caps;
    num_n    = status_i.num ^ tog_num;
    scroll_n = status_i.scroll ^ tog_scroll;

    // shift state as it stands after this byte's key_down write
    lshift_n = (key_ok && !col && key == KLshift) ? !brk : status_i.lshift;
    rshift_n = (key_ok && !col && key == KRshift) ? !brk : status_i.rshift;

    ch_plain = rom_plain(key);
    ch_shift = rom_shift(key);
    letter   = ch_plain inside {[7'h61:7'h7A]};
    shift    = (caps_n && letter) ^ (lshift_n || rshift_n);

    if (col && key != KSlash) begin
      ch = ch_shift;
    end else begin
      ch = shift ? ch_shift : ch_plain;
    end

    upd_o.commit     = valid_i;
    upd_o.ext_d      = is_prefix;
    upd_o.kd_we      = valid_i && key_ok;
    upd_o.kd_key     = key;
    upd_o.kd_col     = col;
    upd_o.kd_set     = !brk;
    upd_o.tog_caps   = tog_caps;
    upd_o.tog_num    = tog_num;
    upd_o.tog_scroll = tog_scroll;

    emit_o = make && ((ch != 7'h00) || led);

    result_o.char_valid   = (ch != 7'h00);
    result_o.char_code    = ch;
    result_o.leds_changed = led;
    result_o.led_bits     = {caps_n, num_n, scroll_n};
  end

endmodule

// ===== rtl/core/keyboard_scancode_to_ascii.sv =====
// Top level of the set 1 keyboard scan code to ASCII decoder.
// Depends on kbd_pkg, kbd_state, kbd_decode and keyboard_scancode_to_ascii_assert.svh.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+------------------------------------------
//   in      | in_valid_i  | in_stall_o  | scan_byte_i
//   out     | out_valid_o | out_stall_i | char_valid_o char_code_o leds_changed_o
//           |             |             | led_bits_o
//
// One scan byte per cycle sustained while the output is not stalled. A beat lands in the
// input register, is decoded from there (ROM lookup, lock toggles, shift bit write) and
// its result beat, if any, is loaded into the output register when the decode stage
// advances; out_valid_o rises once the output register holds that beat.
// Reset clears the shift bits, lock bits and prefix flag at once; no warm-up.
// A stalled output beat holds; the input register still takes one more byte and then
// in_stall_o rises. Bytes that give no result (prefix, break, unknown keys) still
// wait for a free output slot before they are decoded.
`timescale 1ns / 1ps
`include "keyboard_scancode_to_ascii_assert.svh"

module keyboard_scancode_to_ascii
  import kbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [6:0] char_code_o,
  output logic       leds_changed_o,
  output logic [2:0] led_bits_o
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  scan_q;
  logic        out_vld_q, out_vld_d;
  kbd_result_t res_q;

  logic        advance, accept, commit, emit;
  kbd_update_t upd;
  kbd_status_t status;
  kbd_result_t res;

  // decode stage moves whenever the output slot is free or being drained
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign commit     = in_vld_q && advance;

  assign in_vld_d  = in_stall_o ? in_vld_q : in_valid_i;
  assign out_vld_d = advance ? (commit && emit) : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      scan_q <= scan_byte_i;
    end
    if (commit && emit) begin
      res_q <= res;
    end
  end

  kbd_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .status_o (status)
  );

  kbd_decode u_decode (
    .valid_i     (commit),
    .scan_byte_i (scan_q),
    .status_i    (status),
    .upd_o       (upd),
    .emit_o      (emit),
    .result_o    (res)
  );

  assign out_valid_o    = out_vld_q;
  assign char_valid_o   = res_q.char_valid;
  assign char_code_o    = res_q.char_code;
  assign leds_changed_o = res_q.leds_changed;
  assign led_bits_o     = res_q.led_bits;

  // a result beat always carries a character or an LED update
  `KSA_ASSERT_IMPLIES(a_no_empty_beat, out_vld_q, char_valid_o || leds_changed_o)
  // char_valid tracks a non-zero code
  `KSA_ASSERT_IMPLIES(a_code_flag, out_vld_q, char_valid_o == (char_code_o != 7'h00))
  // input side stalls only when both registers are full
  `KSA_ASSERT_IMPLIES(a_stall_full, in_stall_o, in_vld_q && out_vld_q && out_stall_i)
  // a stalled decode stage keeps its byte
  `KSA_ASSERT_NEXT(a_hold_byte, in_vld_q && !advance, in_vld_q && $stable(scan_q))

endmodule
